>>> hdl/spq_pkg.sv
// spq_pkg: command and status codes, plus the control and status structs
// that join the sorted priority queue controller and its datapath.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam int PRIO_BITS = 16;
    localparam int PORT_TAG_BITS = 16;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       wr_en;
        logic       wr_sel_new;
        logic       set_status;
        logic [1:0] status_code;
        logic       cap_popped;
        logic       out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       prio_gt;
        logic       tag_eq;
        logic       out_free;
    } dp_stat_t;

endpackage

>>> hdl/spq_datapath.sv
// spq_datapath: entry memory, command payload registers, compares and the
// result register of the sorted priority queue.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_datapath #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        s_cmd,
    input  logic [15:0]       s_patient_tag,
    input  logic [15:0]       s_priority_req,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [15:0]       m_popped_tag,
    output logic              m_front_valid,
    output logic [15:0]       m_front_tag,
    output logic [15:0]       m_front_priority,
    output logic [4:0]        m_occupancy_count,
    input  spq_pkg::dp_cmd_t  cmd_i,
    output spq_pkg::dp_stat_t stat_o,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [CW-1:0]     count
);
    import spq_pkg::*;

    localparam int TW = (TAG_BITS < PORT_TAG_BITS) ? TAG_BITS : PORT_TAG_BITS;
    localparam int EW = PRIO_BITS + TW;

    logic [EW-1:0]        mem [CAPACITY];
    logic [EW-1:0]        rd_data_reg;
    logic [EW-1:0]        wr_data;
    logic [1:0]           cmd_reg;
    logic [TW-1:0]        tag_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [1:0]           status_reg;
    logic [TW-1:0]        popped_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_status_reg;
    logic [15:0]          m_popped_reg;
    logic                 m_front_valid_reg;
    logic [15:0]          m_front_tag_reg;
    logic [15:0]          m_front_prio_reg;
    logic [4:0]           m_occ_reg;

    logic [TW-1:0]        rd_tag;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [TW+15:0]       popped_ext;
    logic [TW+15:0]       front_tag_ext;
    logic [CW+4:0]        count_ext;
    logic                 not_empty;

    assign rd_tag  = rd_data_reg[TW-1:0];
    assign rd_prio = rd_data_reg[EW-1:TW];
    assign wr_data = cmd_i.wr_sel_new ? {prio_reg, tag_reg} : rd_data_reg;

    assign popped_ext    = {16'b0, popped_reg};
    assign front_tag_ext = {16'b0, rd_tag};
    assign count_ext     = {5'b0, count};
    assign not_empty     = (count != '0);

    assign stat_o.cmd      = cmd_reg;
    assign stat_o.prio_gt  = (rd_prio > prio_reg);
    assign stat_o.tag_eq   = (rd_tag == tag_reg);
    assign stat_o.out_free = !m_valid_reg || m_ready;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd_i.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_in) begin
            cmd_reg    <= s_cmd;
            tag_reg    <= s_patient_tag[TW-1:0];
            prio_reg   <= s_priority_req;
            status_reg <= ST_OK;
            popped_reg <= '0;
        end else begin
            if (cmd_i.set_status) begin
                status_reg <= cmd_i.status_code;
            end
            if (cmd_i.cap_popped) begin
                popped_reg <= rd_tag;
            end
        end
    end

    // result register, front comes from slot 0 read in the cycle before
    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_status_reg      <= status_reg;
            m_popped_reg      <= popped_ext[15:0];
            m_front_valid_reg <= not_empty;
            m_front_tag_reg   <= not_empty ? front_tag_ext[15:0] : 16'd0;
            m_front_prio_reg  <= not_empty ? rd_prio : 16'd0;
            m_occ_reg         <= count_ext[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_popped_tag      = m_popped_reg;
    assign m_front_valid     = m_front_valid_reg;
    assign m_front_tag       = m_front_tag_reg;
    assign m_front_priority  = m_front_prio_reg;
    assign m_occupancy_count = m_occ_reg;

endmodule

>>> hdl/spq_ctrl.sv
// spq_ctrl: command sequencer of the sorted priority queue; holds the entry
// count and the scan index and drives the datapath memory addresses.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl #(
    parameter int CAPACITY = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output spq_pkg::dp_cmd_t  cmd_o,
    input  spq_pkg::dp_stat_t stat_i,
    output logic [AW-1:0]     rd_addr,
    output logic [AW-1:0]     wr_addr,
    output logic [CW-1:0]     count
);
    import spq_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_INS_START = 4'd2;
    localparam logic [3:0] S_INS_RD    = 4'd3;
    localparam logic [3:0] S_INS_CMP   = 4'd4;
    localparam logic [3:0] S_INS_PUT   = 4'd5;
    localparam logic [3:0] S_POP_RD    = 4'd6;
    localparam logic [3:0] S_POP_CAP   = 4'd7;
    localparam logic [3:0] S_SHF_CHK   = 4'd8;
    localparam logic [3:0] S_SHF_WR    = 4'd9;
    localparam logic [3:0] S_SRCH_RD   = 4'd10;
    localparam logic [3:0] S_SRCH_CMP  = 4'd11;
    localparam logic [3:0] S_FRONT_RD  = 4'd12;
    localparam logic [3:0] S_OUT       = 4'd13;

    localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_dec, k_inc;

    assign k_dec = k_reg - 1'b1;
    assign k_inc = k_reg + 1'b1;
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        count_next = count_reg;
        cmd_o      = '0;
        rd_addr    = '0;
        wr_addr    = k_reg[AW-1:0];
        s_ready    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.load_in = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (stat_i.cmd)
                    OP_INSERT: begin
                        if (count_reg == CAP_CW) begin
                            cmd_o.set_status  = 1'b1;
                            cmd_o.status_code = ST_FULL;
                            state_next        = S_FRONT_RD;
                        end else begin
                            state_next = S_INS_START;
                        end
                    end
                    OP_POP: begin
                        if (count_reg == '0) begin
                            cmd_o.set_status  = 1'b1;
                            cmd_o.status_code = ST_EMPTY;
                            state_next        = S_FRONT_RD;
                        end else begin
                            state_next = S_POP_RD;
                        end
                    end
                    OP_CHANGE: begin
                        if (count_reg == '0) begin
                            cmd_o.set_status  = 1'b1;
                            cmd_o.status_code = ST_EMPTY;
                            state_next        = S_FRONT_RD;
                        end else begin
                            k_next     = '0;
                            state_next = S_SRCH_RD;
                        end
                    end
                    default: begin
                        count_next = '0;
                        state_next = S_FRONT_RD;
                    end
                endcase
            end
            // insert scans from the back, moving larger entries up one slot
            S_INS_START: begin
                k_next     = count_reg;
                state_next = (count_reg == '0) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_RD: begin
                rd_addr    = k_dec[AW-1:0];
                state_next = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (stat_i.prio_gt) begin
                    cmd_o.wr_en = 1'b1;
                    k_next      = k_dec;
                    state_next  = (k_dec == '0) ? S_INS_PUT : S_INS_RD;
                end else begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                cmd_o.wr_en      = 1'b1;
                cmd_o.wr_sel_new = 1'b1;
                count_next       = count_reg + 1'b1;
                state_next       = S_FRONT_RD;
            end
            S_POP_RD: begin
                state_next = S_POP_CAP;
            end
            S_POP_CAP: begin
                cmd_o.cap_popped = 1'b1;
                k_next           = '0;
                state_next       = S_SHF_CHK;
            end
            // removal closes the gap at k by moving later entries down
            S_SHF_CHK: begin
                if (k_inc < count_reg) begin
                    rd_addr    = k_inc[AW-1:0];
                    state_next = S_SHF_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = (stat_i.cmd == OP_CHANGE) ? S_INS_START : S_FRONT_RD;
                end
            end
            S_SHF_WR: begin
                cmd_o.wr_en = 1'b1;
                k_next      = k_inc;
                state_next  = S_SHF_CHK;
            end
            S_SRCH_RD: begin
                rd_addr    = k_reg[AW-1:0];
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (stat_i.tag_eq) begin
                    state_next = S_SHF_CHK;
                end else if (k_inc == count_reg) begin
                    cmd_o.set_status  = 1'b1;
                    cmd_o.status_code = ST_MISSING;
                    state_next        = S_FRONT_RD;
                end else begin
                    k_next     = k_inc;
                    state_next = S_SRCH_RD;
                end
            end
            S_FRONT_RD: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                // rd_addr stays at slot 0 so the front data holds while stalled
                if (stat_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue, one command beat in, one result beat out.
// The time from accept to result valid grows with the entries searched and moved, since
// the one-read one-write entry memory handles them one at a time. Next beat is taken the
// cycle after the result loads, even while it waits. Reset (aresetn low, synchronous)
// empties the queue.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int CAPACITY = 16,
    parameter int TAG_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_patient_tag,
    input  logic [15:0] s_priority_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_popped_tag,
    output logic        m_front_valid,
    output logic [15:0] m_front_tag,
    output logic [15:0] m_front_priority,
    output logic [4:0]  m_occupancy_count
);
    import spq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    dp_cmd_t       dp_cmd;
    dp_stat_t      dp_stat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] count;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd_o   (dp_cmd),
        .stat_i  (dp_stat),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .count   (count)
    );

    spq_datapath #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_cmd             (s_cmd),
        .s_patient_tag     (s_patient_tag),
        .s_priority_req    (s_priority_req),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_popped_tag      (m_popped_tag),
        .m_front_valid     (m_front_valid),
        .m_front_tag       (m_front_tag),
        .m_front_priority  (m_front_priority),
        .m_occupancy_count (m_occupancy_count),
        .cmd_i             (dp_cmd),
        .stat_o            (dp_stat),
        .rd_addr           (rd_addr),
        .wr_addr           (wr_addr),
        .count             (count)
    );

endmodule

>>> dv/sorted_priority_queue_test.sv
// sorted_priority_queue_test: self-checking bench for the sorted priority queue, a directed
// command table then random command traffic under idle, stall and back-pressure phases.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int CAPACITY = 16;
    localparam int TAG_BITS = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int END_WAIT = 6 * CAPACITY + 24;
    localparam int HOLD_CYCLES = 400;
    localparam int N_DIRECTED = 18;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_tag;
        logic        front_valid;
        logic [15:0] front_tag;
        logic [15:0] front_priority;
        logic [4:0]  count;
    } result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] tag;
        logic [15:0] prio;
        logic        typed;
        result_t     want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [15:0] s_patient_tag;
    logic [15:0] s_priority_req;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_popped_tag;
    logic        m_front_valid;
    logic [15:0] m_front_tag;
    logic [15:0] m_front_priority;
    logic [4:0]  m_occupancy_count;

    // queue contents in serving order, slot 0 is the front
    logic [15:0] model_tags [CAPACITY];
    logic [15:0] model_prios [CAPACITY];
    int          model_count = 0;

    result_t     awaited[$];
    result_t     head_want;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;

    // rows with typed = 1 carry their result; the rest go through the predictor
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{OP_POP,    16'h0000, 16'h0000, 1'b1, '{ST_EMPTY,   16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}},
        '{OP_CHANGE, 16'h1234, 16'h0005, 1'b1, '{ST_EMPTY,   16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}},
        '{OP_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_OK,      16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}},
        '{OP_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_OK,      16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, 5'd1}},
        // lands ahead of the head, old head must survive
        '{OP_INSERT, 16'h0000, 16'h0000, 1'b1, '{ST_OK,      16'h0000, 1'b1, 16'h0000, 16'h0000, 5'd2}},
        '{OP_INSERT, 16'h00AA, 16'h0000, 1'b1, '{ST_OK,      16'h0000, 1'b1, 16'h0000, 16'h0000, 5'd3}},
        '{OP_CHANGE, 16'h5555, 16'h0007, 1'b1, '{ST_MISSING, 16'h0000, 1'b1, 16'h0000, 16'h0000, 5'd3}},
        // change of the head entry itself
        '{OP_CHANGE, 16'h0000, 16'hFFFF, 1'b1, '{ST_OK,      16'h0000, 1'b1, 16'h00AA, 16'h0000, 5'd3}},
        '{OP_POP,    16'h0000, 16'h0000, 1'b1, '{ST_OK,      16'h00AA, 1'b1, 16'hFFFF, 16'hFFFF, 5'd2}},
        '{OP_POP,    16'h0000, 16'h0000, 1'b1, '{ST_OK,      16'hFFFF, 1'b1, 16'h0000, 16'hFFFF, 5'd1}},
        '{OP_POP,    16'hFFFF, 16'hFFFF, 1'b1, '{ST_OK,      16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}},
        '{OP_POP,    16'h0000, 16'h0000, 1'b1, '{ST_EMPTY,   16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}},
        // duplicate tags, a change moves only the first match
        '{OP_INSERT, 16'h0007, 16'h000A, 1'b0, '0},
        '{OP_INSERT, 16'h0007, 16'h0014, 1'b0, '0},
        '{OP_CHANGE, 16'h0007, 16'h001E, 1'b0, '0},
        '{OP_INSERT, 16'h8001, 16'h8000, 1'b0, '0},
        '{OP_CLEAR,  16'h0000, 16'h0000, 1'b1, '{ST_OK,      16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}},
        '{OP_POP,    16'h0000, 16'h0000, 1'b1, '{ST_EMPTY,   16'h0000, 1'b0, 16'h0000, 16'h0000, 5'd0}}
    };

    sorted_priority_queue #(
        .CAPACITY(CAPACITY),
        .TAG_BITS(TAG_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_patient_tag(s_patient_tag),
        .s_priority_req(s_priority_req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_popped_tag(m_popped_tag),
        .m_front_valid(m_front_valid),
        .m_front_tag(m_front_tag),
        .m_front_priority(m_front_priority),
        .m_occupancy_count(m_occupancy_count)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // insert behind every entry of equal or lower priority value
    function automatic void place_entry(input logic [15:0] tag, input logic [15:0] prio);
        int pos;
        int k;
        pos = 0;
        while (pos < model_count && model_prios[pos] <= prio) pos++;
        for (k = model_count; k > pos; k--) begin
            model_tags[k] = model_tags[k - 1];
            model_prios[k] = model_prios[k - 1];
        end
        model_tags[pos] = tag;
        model_prios[pos] = prio;
        model_count++;
    endfunction

    function automatic void drop_entry(input int pos);
        int k;
        for (k = pos; k + 1 < model_count; k++) begin
            model_tags[k] = model_tags[k + 1];
            model_prios[k] = model_prios[k + 1];
        end
        model_count--;
    endfunction

    function automatic result_t apply_command(input logic [1:0] cmd, input logic [15:0] tag,
                                              input logic [15:0] prio);
        result_t r;
        int pos;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            OP_INSERT: begin
                if (model_count >= CAPACITY) r.status = ST_FULL;
                else place_entry(tag, prio);
            end
            OP_POP: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_tag = model_tags[0];
                    drop_entry(0);
                end
            end
            OP_CHANGE: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < model_count && model_tags[pos] != tag) pos++;
                    if (pos >= model_count) begin
                        r.status = ST_MISSING;
                    end else begin
                        drop_entry(pos);
                        place_entry(tag, prio);
                    end
                end
            end
            default: model_count = 0;
        endcase
        if (model_count > 0) begin
            r.front_valid = 1'b1;
            r.front_tag = model_tags[0];
            r.front_priority = model_prios[0];
        end
        r.count = 5'(model_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h, wanted %h", name, got, want));
    endtask

    // called right after a rising edge; returns at the edge the beat is taken (or after a gap)
    task automatic issue_command(input logic [1:0] cmd, input logic [15:0] tag,
                                 input logic [15:0] prio, input logic typed,
                                 input result_t typed_want);
        result_t predicted;
        int gap;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_patient_tag <= tag;
        s_priority_req <= prio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_command(cmd, tag, prio);
        awaited.push_back(typed ? typed_want : predicted);
        gap = 0;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap = ($urandom_range(3) == 0) ? $urandom_range(8, 110) : $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_tag();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 16'($urandom_range(7));
        if (r < 65) return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] rand_prio();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 16'($urandom_range(3));
        if (r < 50) return ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // chunks of fills up to or past full, drains up to or past empty, clears and mixed
    // commands; every call opens with a fill so the queue always reaches full
    task automatic run_traffic(input int n_items);
        int sent;
        int kind;
        int len;
        int k;
        int r;
        logic [1:0]  cmd;
        logic [15:0] tag;
        sent = 0;
        while (sent < n_items) begin
            kind = (sent == 0) ? 0 : $urandom_range(99);
            if (kind < 20) begin
                len = CAPACITY - model_count + $urandom_range(2);
                for (k = 0; k < len; k++)
                    issue_command(OP_INSERT, rand_tag(), rand_prio(), 1'b0, '0);
            end else if (kind < 35) begin
                len = model_count + $urandom_range(2);
                for (k = 0; k < len; k++)
                    issue_command(OP_POP, 16'($urandom), 16'($urandom), 1'b0, '0);
            end else if (kind < 38) begin
                len = 1;
                issue_command(OP_CLEAR, 16'($urandom), 16'($urandom), 1'b0, '0);
            end else begin
                len = $urandom_range(1, 24);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(99);
                    cmd = (r < 45) ? OP_INSERT : (r < 72) ? OP_POP : (r < 98) ? OP_CHANGE
                                                                            : OP_CLEAR;
                    tag = rand_tag();
                    // changes mostly aim at a tag that is held
                    if (cmd == OP_CHANGE && model_count > 0 && $urandom_range(99) < 70)
                        tag = model_tags[$urandom_range(model_count - 1)];
                    issue_command(cmd, tag, rand_prio(), 1'b0, '0);
                end
            end
            sent += len;
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing awaited, status %0d",
                                          m_status));
            end else begin
                head_want = awaited.pop_front();
                check_field("status", m_status, head_want.status);
                check_field("popped_tag", m_popped_tag, head_want.popped_tag);
                check_field("front_valid", m_front_valid, head_want.front_valid);
                check_field("front_tag", m_front_tag, head_want.front_tag);
                check_field("front_priority", m_front_priority, head_want.front_priority);
                check_field("occupancy_count", m_occupancy_count, head_want.count);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = OP_INSERT;
        s_patient_tag = '0;
        s_priority_req = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            issue_command(DIRECTED[i].cmd, DIRECTED[i].tag, DIRECTED[i].prio,
                          DIRECTED[i].typed, DIRECTED[i].want);
        drain_results();

        send_idle_pct = 0;
        run_traffic(450);
        drain_results();

        send_idle_pct = 48;
        run_traffic(400);
        drain_results();

        send_idle_pct = 0;
        recv_stall_pct <= 48;
        run_traffic(400);
        drain_results();

        send_idle_pct = 29;
        recv_stall_pct <= 29;
        run_traffic(400);
        drain_results();

        // long receiver hold-off while commands keep coming, input must back up
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_req <= 1'b1;
        run_traffic(300);

        drain_results();
        repeat (END_WAIT) @(posedge aclk);
        if (awaited.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited.size()));
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
